// ===== rtl/core/thkt_pkg.sv =====
// package for the two-key hash table: default sizes, opcodes, status codes
// and controller states; no dependencies
`timescale 1ns / 1ps

package thkt_pkg;

    localparam int THKT_FIRST_BUCKETS  = 16;
    localparam int THKT_SECOND_BUCKETS = 64;
    localparam int THKT_BUCKET_WAYS    = 4;
    localparam int THKT_HANDLE_BITS    = 16;

    localparam int THKT_KEY_W      = 31;
    localparam int THKT_ITEM_HANDLE_W = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_FILL,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // address width for a count of v, at least one bit
    function automatic int thkt_width(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

endpackage

// ===== rtl/core/thkt_if.sv =====
// request and response channels of the two-key hash table
// depends on thkt_pkg for field widths
`timescale 1ns / 1ps

interface thkt_req_if
    import thkt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [THKT_KEY_W-1:0]         client_id;
    logic [THKT_KEY_W-1:0]         creator_id;
    logic [THKT_ITEM_HANDLE_W-1:0] item_handle;

    modport source (output valid, opcode, client_id, creator_id, item_handle, input ready);
    modport sink   (input valid, opcode, client_id, creator_id, item_handle, output ready);
endinterface

interface thkt_rsp_if
    import thkt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [THKT_ITEM_HANDLE_W-1:0] found_handle;

    modport source (output valid, status, found_handle, input ready);
    modport sink   (input valid, status, found_handle, output ready);
endinterface

// ===== rtl/core/two_key_hash_table.sv =====
// two-key hash table: request/response channels (thkt_req_if, thkt_rsp_if)
// opcodes: add, find, remove, clear all. one request is taken at a time;
// the request channel is ready only while the controller is idle.
// bucket = (client mod FIRST_BUCKETS) * SECOND_BUCKETS + (creator mod SECOND_BUCKETS);
// each bucket holds BUCKET_WAYS entries in insertion order in one entry ram,
// the per-bucket fill counts live in a second ram.
// steps from request beat to response valid:
//   add              hash, fill read, update, response
//   find / remove    hash, fill read, entry scan up to the fill count; the scan
//                    reads one entry a cycle through the single compare unit;
//                    remove then moves later entries down, one per cycle
//   clear            one fill count written per cycle, over all NUM_BUCKETS
// the next request is taken the cycle after the response register loads.
// after reset the fill ram is swept to zero, all NUM_BUCKETS counts (1024 at
// the default sizes), before the request channel first goes ready.
// the response sits in an output register; the next request is taken while it
// waits, and a second response waits in the response state until the receiver
// takes the first, so a stalled receiver holds everything without loss.
// depends on thkt_pkg, thkt_if and thkt_bucket_hash
`timescale 1ns / 1ps

module two_key_hash_table
    import thkt_pkg::*;
#(
    parameter int FIRST_BUCKETS  = THKT_FIRST_BUCKETS,
    parameter int SECOND_BUCKETS = THKT_SECOND_BUCKETS,
    parameter int BUCKET_WAYS    = THKT_BUCKET_WAYS,
    parameter int HANDLE_BITS    = THKT_HANDLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thkt_req_if.sink   i_req,
    thkt_rsp_if.source o_rsp
);

    localparam int NUM_BUCKETS = FIRST_BUCKETS * SECOND_BUCKETS;
    localparam int NUM_ENTRIES = NUM_BUCKETS * BUCKET_WAYS;
    localparam int BK_W  = thkt_width(NUM_BUCKETS);
    localparam int EA_W  = thkt_width(NUM_ENTRIES);
    localparam int FL_W  = $clog2(BUCKET_WAYS + 1);
    localparam int HW    = (HANDLE_BITS < THKT_ITEM_HANDLE_W) ? HANDLE_BITS : THKT_ITEM_HANDLE_W;
    localparam int KEY_W = 2 * THKT_KEY_W;
    localparam int ENT_W = KEY_W + HW;

    // memories
    logic [ENT_W-1:0] r_ent_mem [NUM_ENTRIES];
    logic [FL_W-1:0]  r_fill_mem [NUM_BUCKETS];
    logic [ENT_W-1:0] r_ent_rd;
    logic [FL_W-1:0]  r_fill_rd;

    // control and payload registers
    t_state                        r_state, n_state;
    t_opcode                       r_op, n_op;
    logic [THKT_KEY_W-1:0]         r_client, n_client;
    logic [THKT_KEY_W-1:0]         r_creator, n_creator;
    logic [HW-1:0]                 r_handle, n_handle;
    logic [BK_W-1:0]               r_bucket, n_bucket;
    logic [EA_W-1:0]               r_base, n_base;
    logic [FL_W-1:0]               r_fill, n_fill;
    logic [FL_W-1:0]               r_idx, n_idx;
    logic [FL_W-1:0]               r_wr_idx, n_wr_idx;
    logic [FL_W-1:0]               r_cmp_idx, n_cmp_idx;
    logic                          r_cmp_valid, n_cmp_valid;
    logic                          r_hit, n_hit;
    logic [FL_W-1:0]               r_pos, n_pos;
    logic [BK_W-1:0]               r_clr_addr, n_clr_addr;
    logic                          r_clr_op, n_clr_op;
    t_status                       r_sts, n_sts;
    logic [THKT_ITEM_HANDLE_W-1:0] r_fhandle, n_fhandle;
    logic                          r_out_valid, n_out_valid;
    t_status                       r_out_status, n_out_status;
    logic [THKT_ITEM_HANDLE_W-1:0] r_out_handle, n_out_handle;

    // memory controls
    logic             w_ent_we;
    logic [EA_W-1:0]  w_ent_waddr;
    logic [ENT_W-1:0] w_ent_wdata;
    logic [EA_W-1:0]  w_ent_raddr;
    logic             w_fill_we;
    logic [BK_W-1:0]  w_fill_waddr;
    logic [FL_W-1:0]  w_fill_wdata;

    logic             w_accept;
    t_opcode          w_req_op;
    logic             w_hash_start;
    logic             w_hash_done;
    logic [BK_W-1:0]  w_hash_bucket;
    logic             w_key_hit;
    logic             w_last;
    logic             w_any_hit;
    logic [FL_W-1:0]  w_pos;
    logic             w_resp_load;

    assign w_req_op     = t_opcode'(i_req.opcode);
    assign w_accept     = i_req.valid && (r_state == S_IDLE);
    assign w_hash_start = w_accept && (w_req_op != OP_CLEAR);

    thkt_bucket_hash #(
        .FIRST_BUCKETS  (FIRST_BUCKETS),
        .SECOND_BUCKETS (SECOND_BUCKETS)
    ) u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_hash_start),
        .i_client_id  (i_req.client_id),
        .i_creator_id (i_req.creator_id),
        .o_done       (w_hash_done),
        .o_bucket     (w_hash_bucket)
    );

    // shared compare unit: one stored entry against the request key per cycle
    assign w_key_hit   = (r_ent_rd[ENT_W-1 -: KEY_W] == {r_client, r_creator});
    assign w_last      = r_cmp_valid && (r_idx == r_fill);
    assign w_any_hit   = r_hit || (r_cmp_valid && w_key_hit);
    assign w_pos       = (r_cmp_valid && w_key_hit) ? r_cmp_idx : r_pos;
    assign w_resp_load = !r_out_valid || o_rsp.ready;

    assign w_ent_raddr = r_base + EA_W'(r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_clr_addr == BK_W'(NUM_BUCKETS - 1)) begin
                    n_state = r_clr_op ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (w_req_op == OP_CLEAR) ? S_INIT : S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: n_state = S_EXEC;
            S_EXEC: begin
                if (r_op == OP_ADD || r_fill_rd == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (r_cmp_valid && w_key_hit && r_op == OP_FIND) begin
                    n_state = S_RESP;
                end else if (w_last) begin
                    if (r_op == OP_REMOVE && w_any_hit && (w_pos + 1'b1 != r_fill)) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SHIFT: begin
                if (w_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_resp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_op         = r_op;
        n_client     = r_client;
        n_creator    = r_creator;
        n_handle     = r_handle;
        n_bucket     = r_bucket;
        n_base       = r_base;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_wr_idx     = r_wr_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_valid  = r_cmp_valid;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_clr_addr   = r_clr_addr;
        n_clr_op     = r_clr_op;
        n_sts        = r_sts;
        n_fhandle    = r_fhandle;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;

        w_ent_we     = 1'b0;
        w_ent_waddr  = r_base + EA_W'(r_wr_idx);
        w_ent_wdata  = r_ent_rd;
        w_fill_we    = 1'b0;
        w_fill_waddr = r_bucket;
        w_fill_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = r_clr_addr;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == BK_W'(NUM_BUCKETS - 1)) begin
                    n_clr_op = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = w_req_op;
                    n_client   = i_req.client_id;
                    n_creator  = i_req.creator_id;
                    n_handle   = HW'(i_req.item_handle);
                    n_sts      = STS_OK;
                    n_fhandle  = '0;
                    n_clr_addr = '0;
                    n_clr_op   = (w_req_op == OP_CLEAR);
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_bucket = w_hash_bucket;
                end
            end
            S_FILL: begin
                n_base = EA_W'(EA_W'(r_bucket) * EA_W'(BUCKET_WAYS));
            end
            S_EXEC: begin
                n_fill      = r_fill_rd;
                n_idx       = '0;
                n_cmp_valid = 1'b0;
                n_hit       = 1'b0;
                if (r_op == OP_ADD) begin
                    if (r_fill_rd == FL_W'(BUCKET_WAYS)) begin
                        n_sts = STS_FULL;
                    end else begin
                        w_ent_we     = 1'b1;
                        w_ent_waddr  = r_base + EA_W'(r_fill_rd);
                        w_ent_wdata  = {r_client, r_creator, r_handle};
                        w_fill_we    = 1'b1;
                        w_fill_wdata = r_fill_rd + 1'b1;
                    end
                end else if (r_fill_rd == '0) begin
                    n_sts = STS_NOT_FOUND;
                end
            end
            S_SCAN: begin
                // issue the next read while comparing the previous one
                if (r_idx != r_fill) begin
                    n_idx       = r_idx + 1'b1;
                    n_cmp_idx   = r_idx;
                    n_cmp_valid = 1'b1;
                end else begin
                    n_cmp_valid = 1'b0;
                end
                if (r_cmp_valid && w_key_hit) begin
                    n_hit = 1'b1;
                    n_pos = r_cmp_idx;
                end
                priority if (r_cmp_valid && w_key_hit && r_op == OP_FIND) begin
                    n_fhandle = THKT_ITEM_HANDLE_W'(r_ent_rd[HW-1:0]);
                end else if (w_last) begin
                    if (!w_any_hit) begin
                        n_sts = STS_NOT_FOUND;
                    end else if (r_op == OP_REMOVE) begin
                        w_fill_we    = 1'b1;
                        w_fill_wdata = r_fill - 1'b1;
                        n_idx        = w_pos + 1'b1;
                        n_wr_idx     = w_pos;
                        n_cmp_valid  = 1'b0;
                    end
                end else begin
                    n_sts = r_sts;
                end
            end
            S_SHIFT: begin
                // read entry j+1 ahead, write it back at j the next cycle
                if (r_idx != r_fill) begin
                    n_idx       = r_idx + 1'b1;
                    n_cmp_valid = 1'b1;
                end else begin
                    n_cmp_valid = 1'b0;
                end
                if (r_cmp_valid) begin
                    w_ent_we = 1'b1;
                    n_wr_idx = r_wr_idx + 1'b1;
                end
            end
            S_RESP: begin
                if (w_resp_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_sts;
                    n_out_handle = r_fhandle;
                end
            end
            default: begin
                n_sts = r_sts;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_ent_mem[w_ent_waddr] <= w_ent_wdata;
        end
        r_ent_rd <= r_ent_mem[w_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_fill_mem[w_fill_waddr] <= w_fill_wdata;
        end
        r_fill_rd <= r_fill_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_op    <= n_clr_op;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_client     <= n_client;
        r_creator    <= n_creator;
        r_handle     <= n_handle;
        r_bucket     <= n_bucket;
        r_base       <= n_base;
        r_fill       <= n_fill;
        r_idx        <= n_idx;
        r_wr_idx     <= n_wr_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_sts        <= n_sts;
        r_fhandle    <= n_fhandle;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_handle = r_out_handle;

endmodule

// ===== rtl/core/thkt_bucket_hash.sv =====
// bucket index pipeline: (client mod FIRST) * SECOND + (creator mod SECOND)
// mod by constant through reciprocal multiply; depends on thkt_pkg
`timescale 1ns / 1ps

module thkt_bucket_hash
    import thkt_pkg::*;
#(
    parameter int FIRST_BUCKETS  = THKT_FIRST_BUCKETS,
    parameter int SECOND_BUCKETS = THKT_SECOND_BUCKETS,
    localparam int BK_W = thkt_width(FIRST_BUCKETS * SECOND_BUCKETS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [THKT_KEY_W-1:0] i_client_id,
    input  logic [THKT_KEY_W-1:0] i_creator_id,
    output logic                  o_done,
    output logic [BK_W-1:0]       o_bucket
);

    localparam int FA_W = thkt_width(FIRST_BUCKETS);
    localparam int SB_W = thkt_width(SECOND_BUCKETS);
    localparam int PR_W = 2 * THKT_KEY_W + 1;

    // reciprocal ceil(2^s / m) with s = key bits + ceil(log2 m) is exact for all keys
    localparam int FA_S = THKT_KEY_W + $clog2(FIRST_BUCKETS);
    localparam int SB_S = THKT_KEY_W + $clog2(SECOND_BUCKETS);
    localparam longint unsigned FA_R =
        ((64'd1 << FA_S) + 64'(FIRST_BUCKETS) - 64'd1) / 64'(FIRST_BUCKETS);
    localparam longint unsigned SB_R =
        ((64'd1 << SB_S) + 64'(SECOND_BUCKETS) - 64'd1) / 64'(SECOND_BUCKETS);
    localparam logic [31:0] FA_RV = FA_R[31:0];
    localparam logic [31:0] SB_RV = SB_R[31:0];

    logic [2:0]            r_vld;
    logic [THKT_KEY_W-1:0] r_cli;
    logic [THKT_KEY_W-1:0] r_cre;
    logic [PR_W-1:0]       r_prod_a;
    logic [PR_W-1:0]       r_prod_b;
    logic [FA_W-1:0]       r_rem_a;
    logic [SB_W-1:0]       r_rem_b;
    logic [BK_W-1:0]       r_bucket;

    logic [THKT_KEY_W-1:0] w_qa;
    logic [THKT_KEY_W-1:0] w_qb;
    logic [FA_W-1:0]       n_rem_a;
    logic [SB_W-1:0]       n_rem_b;
    logic [BK_W-1:0]       n_bucket;

    assign w_qa = THKT_KEY_W'(r_prod_a >> FA_S);
    assign w_qb = THKT_KEY_W'(r_prod_b >> SB_S);

    // remainder is below the modulus, so the low bits of x - q*m are enough
    assign n_rem_a = r_cli[FA_W-1:0] - FA_W'(w_qa[FA_W-1:0] * FA_W'(FIRST_BUCKETS));
    assign n_rem_b = r_cre[SB_W-1:0] - SB_W'(w_qb[SB_W-1:0] * SB_W'(SECOND_BUCKETS));

    assign n_bucket = BK_W'(BK_W'(r_rem_a) * BK_W'(SECOND_BUCKETS)) + BK_W'(r_rem_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cli    <= i_client_id;
            r_cre    <= i_creator_id;
            r_prod_a <= PR_W'(i_client_id) * PR_W'(FA_RV);
            r_prod_b <= PR_W'(i_creator_id) * PR_W'(SB_RV);
        end
        if (r_vld[0]) begin
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
        end
        if (r_vld[1]) begin
            r_bucket <= n_bucket;
        end
    end

    assign o_done   = r_vld[2];
    assign o_bucket = r_bucket;

endmodule
